@@ src/dcbg_pkg.sv @@
`timescale 1ns / 1ps

package dcbg_pkg;

  // Configuration port geometry.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Register indexes, in the order of the register map.
  typedef enum logic [CfgIdxW-1:0] {
    CfgGain      = 3'd0,
    CfgAlpha     = 3'd1,
    CfgThreshold = 3'd2,
    CfgHold      = 3'd3
  } cfg_idx_e;

  // Register widths and reset values.
  localparam int GainW  = 16;
  localparam int AlphaW = 16;
  localparam int ThrW   = 15;
  localparam int HoldW  = 16;

  localparam logic [GainW-1:0]  GainReset  = 16'd5120;
  localparam logic [AlphaW-1:0] AlphaReset = 16'd328;
  localparam logic [ThrW-1:0]   ThrReset   = 15'd500;
  localparam logic [HoldW-1:0]  HoldReset  = 16'd3200;

  // Fraction bits of the DC estimate and of the gain.
  localparam int EstFracW  = 16;
  localparam int GainFracW = 8;

  // Current register contents, handed to the datapath stages.
  typedef struct packed {
    logic [GainW-1:0]  gain;
    logic [AlphaW-1:0] alpha;
    logic [ThrW-1:0]   threshold;
    logic [HoldW-1:0]  hold;
  } cfg_t;

endpackage

@@ src/dcbg_if.sv @@
`timescale 1ns / 1ps

// Input channel: one audio sample per transaction.
interface dcbg_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

// Output channel: one gated sample and its gate flag per transaction.
interface dcbg_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          gate_open;

  modport source (output valid, output out_sample, output gate_open, input ready);
  modport sink   (input valid, input out_sample, input gate_open, output ready);
endinterface

@@ src/dcbg_cfg_regs.sv @@
`timescale 1ns / 1ps

// Register file behind the plain write port. Writes to unmapped indexes
// are dropped, and each register keeps only its own width.
module dcbg_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dcbg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dcbg_pkg::CfgDataW-1:0] cfg_data_i,
  output dcbg_pkg::cfg_t               cfg_o
);

  dcbg_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (dcbg_pkg::cfg_idx_e'(cfg_index_i))
        dcbg_pkg::CfgGain:      cfg_d.gain      = cfg_data_i[dcbg_pkg::GainW-1:0];
        dcbg_pkg::CfgAlpha:     cfg_d.alpha     = cfg_data_i[dcbg_pkg::AlphaW-1:0];
        dcbg_pkg::CfgThreshold: cfg_d.threshold = cfg_data_i[dcbg_pkg::ThrW-1:0];
        dcbg_pkg::CfgHold:      cfg_d.hold      = cfg_data_i[dcbg_pkg::HoldW-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain      <= dcbg_pkg::GainReset;
      cfg_q.alpha     <= dcbg_pkg::AlphaReset;
      cfg_q.threshold <= dcbg_pkg::ThrReset;
      cfg_q.hold      <= dcbg_pkg::HoldReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/dcbg_dc_track.sv @@
`timescale 1ns / 1ps

// First stage: subtracts the DC estimate from the accepted sample and
// updates the estimate in the same cycle. The difference is registered
// for the gain stage.
module dcbg_dc_track #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic [dcbg_pkg::AlphaW-1:0]                   alpha_i,
  input  logic                                         in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0]                in_sample_i,
  output logic                                         in_ready_o,
  output logic                                         diff_valid_o,
  output logic signed [SAMPLE_BITS+dcbg_pkg::EstFracW:0] diff_o,
  input  logic                                         diff_ready_i
);

  localparam int EstW  = SAMPLE_BITS + dcbg_pkg::EstFracW;
  localparam int DiffW = EstW + 1;
  localparam int ProdW = DiffW + dcbg_pkg::AlphaW + 1;

  logic signed [EstW-1:0]  est_d, est_q;
  logic signed [DiffW-1:0] x_scaled, diff, diff_q;
  logic signed [ProdW-1:0] prod, step;
  logic signed [dcbg_pkg::AlphaW:0] alpha_s;
  logic                    valid_q;
  logic                    accept;

  assign in_ready_o = !valid_q || diff_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Sample in the estimate's fixed point, one guard bit for the difference.
  assign x_scaled = {in_sample_i[SAMPLE_BITS-1], in_sample_i, {dcbg_pkg::EstFracW{1'b0}}};
  assign diff     = x_scaled - {est_q[EstW-1], est_q};
  assign alpha_s  = {1'b0, alpha_i};
  assign prod     = ProdW'(diff) * ProdW'(alpha_s);
  // Arithmetic shift gives the floor of the scaled step.
  assign step     = prod >>> dcbg_pkg::EstFracW;
  assign est_d    = est_q + step[EstW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        est_q <= est_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q <= diff;
    end
  end

  assign diff_valid_o = valid_q;
  assign diff_o       = diff_q;

endmodule

@@ src/dcbg_gain_gate.sv @@
`timescale 1ns / 1ps

// Second stage: gain, truncation toward zero, saturation, and the noise
// gate with its hold counter. Results sit in the output register.
module dcbg_gain_gate #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  dcbg_pkg::cfg_t                               cfg_i,
  input  logic                                         diff_valid_i,
  input  logic signed [SAMPLE_BITS+dcbg_pkg::EstFracW:0] diff_i,
  output logic                                         diff_ready_o,
  output logic                                         out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]                out_sample_o,
  output logic                                         gate_open_o,
  input  logic                                         out_ready_i
);

  localparam int DiffW  = SAMPLE_BITS + dcbg_pkg::EstFracW + 1;
  localparam int ProdW  = DiffW + dcbg_pkg::GainW + 1;
  localparam int ShiftW = dcbg_pkg::EstFracW + dcbg_pkg::GainFracW;
  localparam logic signed [ProdW-1:0] RoundAdj = ProdW'((64'd1 << ShiftW) - 64'd1);
  localparam logic signed [ProdW-1:0] SatMax   = ProdW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ProdW-1:0] SatMin   = -SatMax - ProdW'(1);

  logic signed [dcbg_pkg::GainW:0] gain_s;
  logic signed [ProdW-1:0] prod, prod_adj, quot, sat, thr_pos, thr_neg;
  logic                    loud, pass, load;
  logic [dcbg_pkg::HoldW-1:0] hold_eff, hold_d, hold_q;
  logic                    valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                    gate_q;

  assign diff_ready_o = !valid_q || out_ready_i;
  assign load         = diff_valid_i && diff_ready_o;

  assign gain_s   = {1'b0, cfg_i.gain};
  assign prod     = ProdW'(diff_i) * ProdW'(gain_s);
  // Bias negative products so the shift rounds toward zero.
  assign prod_adj = prod[ProdW-1] ? prod + RoundAdj : prod;
  assign quot     = prod_adj >>> ShiftW;

  always_comb begin
    if (quot > SatMax) begin
      sat = SatMax;
    end else if (quot < SatMin) begin
      sat = SatMin;
    end else begin
      sat = quot;
    end
  end

  assign thr_pos  = ProdW'({1'b0, cfg_i.threshold});
  assign thr_neg  = -thr_pos;
  assign loud     = (sat > thr_pos) || (sat < thr_neg);
  assign hold_eff = loud ? cfg_i.hold : hold_q;
  assign pass     = (hold_eff != '0);
  assign hold_d   = pass ? hold_eff - dcbg_pkg::HoldW'(1) : hold_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hold_q  <= '0;
    end else begin
      if (diff_ready_o) begin
        valid_q <= diff_valid_i;
      end
      if (load) begin
        hold_q <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= pass ? sat[SAMPLE_BITS-1:0] : '0;
      gate_q   <= pass;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_sample_o = sample_q;
  assign gate_open_o  = gate_q;

endmodule

@@ src/dc_block_gain_noise_gate.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Payload                      Transaction when
// in_i       sink       in_sample (SAMPLE_BITS, s)   in_i.valid && in_i.ready
// out_o      source     out_sample (SAMPLE_BITS, s), out_o.valid && out_o.ready
//                       gate_open (1)
// cfg        write      cfg_index_i, cfg_data_i      cfg_we_i high
//
// A sample's difference is registered in the DC tracker and its result in
// the gain stage's output register, from which it is offered. A new sample
// is taken every cycle while in_i.ready is high. The rate is set by the DC
// estimate update, a combinational subtract, 16x33 multiply and add.
// Reset clears the DC estimate, the hold counter and both pipeline stages and
// loads the register defaults. A stalled output holds its result while the
// stage behind it keeps one more sample; in_i.ready drops only when both are full.
module dc_block_gain_noise_gate #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcbg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dcbg_pkg::CfgDataW-1:0] cfg_data_i,
  dcbg_in_if.sink                       in_i,
  dcbg_out_if.source                    out_o
);

  dcbg_pkg::cfg_t cfg;

  // Handoff between the DC tracker and the gain stage: the raw difference
  // between the sample and the estimate, in the estimate's fixed point.
  logic                                         diff_valid;
  logic                                         diff_ready;
  logic signed [SAMPLE_BITS+dcbg_pkg::EstFracW:0] diff;

  // Register file. Writes are expected only while no sample is in flight.
  dcbg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The estimate advances on every input transaction, so the leaky average
  // sees samples in order with no gaps even when the output stalls.
  dcbg_dc_track #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .alpha_i      (cfg.alpha),
    .in_valid_i   (in_i.valid),
    .in_sample_i  (in_i.in_sample),
    .in_ready_o   (in_i.ready),
    .diff_valid_o (diff_valid),
    .diff_o       (diff),
    .diff_ready_i (diff_ready)
  );

  // The hold counter moves once per result, when the result is registered.
  dcbg_gain_gate #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_gate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .diff_valid_i (diff_valid),
    .diff_i       (diff),
    .diff_ready_o (diff_ready),
    .out_valid_o  (out_o.valid),
    .out_sample_o (out_o.out_sample),
    .gate_open_o  (out_o.gate_open),
    .out_ready_i  (out_o.ready)
  );

endmodule

@@ src/dcbg_checker.sv @@
`timescale 1ns / 1ps

module dcbg_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_sample_i,
  input logic                   gate_open_i
);

  // A silenced result carries a zero sample.
  a_closed_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !gate_open_i) |-> (out_sample_i == '0))
    else $error("gated result with nonzero sample");

  // Input back-pressure only when the output is full and stalled.
  a_ready_low_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without an output stall");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_sample_i) && $stable(gate_open_i)))
    else $error("stalled result changed");

  // An empty output can only turn valid after an input transaction has passed the DC tracker register.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without an input transaction");

endmodule

bind dc_block_gain_noise_gate dcbg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_dcbg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.out_sample),
  .gate_open_i  (out_o.gate_open)
);
